FILE: hdl/gpv_pkg.sv
package gpv_pkg;

	localparam int BAND_COUNT = 4;
	localparam int BAND_W = 2;
	localparam int SAMPLE_W = 16;
	localparam int OUT_W = 9;
	localparam int GAIN_W = 8;
	localparam int COEF_W = 49;
	localparam int PHASE_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int ITER_W = 4;
	localparam int CORDIC_STEPS = 15;

	localparam int FRAME_LEN_DEF = 32;
	localparam int SINE_ENTRIES_DEF = 2048;
	localparam int AVG_WINDOW_DEF = 4;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INTENSITY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HARMONIC = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MODULATION = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BAND0 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BAND1 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_BAND2 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_BAND3 = 3'd7;

	typedef logic [COEF_W-1:0] coef_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_LP0,
		OP_LP1,
		OP_LP2,
		OP_BANDS,
		OP_ENV_RD,
		OP_ENV_WR,
		OP_RES_MUL,
		OP_RES_ADD,
		OP_FE_MUL,
		OP_FE_VEC,
		OP_NORM,
		OP_ROT,
		OP_PHASE,
		OP_DIFF,
		OP_INC_MUL,
		OP_INC_SET,
		OP_ADV,
		OP_SYN_STEP,
		OP_SYN_ROM,
		OP_SYN_MUL,
		OP_SYN_ACC,
		OP_G1_MUL,
		OP_G1,
		OP_G2_MUL,
		OP_G2,
		OP_G3_MUL,
		OP_G3,
		OP_CLAMP,
		OP_OUT,
		OP_OUT_ZERO
	} dp_op_t;

	typedef struct packed {
		dp_op_t              op;
		logic [BAND_W-1:0]   band;
		logic [ITER_W-1:0]   iter;
	} dp_cmd_t;

	typedef struct packed {
		logic frame_last;
		logic vec_zero;
		logic norm_small;
	} dp_stat_t;

	// arctangent of 2^-i in binary angle units
	function automatic logic [PHASE_W-1:0] atan_step(input logic [ITER_W-1:0] i);
		logic [PHASE_W-1:0] r;
		case (i)
			4'd0: r = 16'd8192;
			4'd1: r = 16'd4836;
			4'd2: r = 16'd2555;
			4'd3: r = 16'd1297;
			4'd4: r = 16'd651;
			4'd5: r = 16'd326;
			4'd6: r = 16'd163;
			4'd7: r = 16'd81;
			4'd8: r = 16'd41;
			4'd9: r = 16'd20;
			4'd10: r = 16'd10;
			4'd11: r = 16'd5;
			4'd12: r = 16'd3;
			4'd13: r = 16'd1;
			4'd14: r = 16'd1;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

	// combined level and output shift of each band
	function automatic logic [3:0] band_shift(input logic [BAND_W-1:0] b);
		logic [3:0] r;
		case (b)
			2'd0: r = 4'd9;
			2'd1: r = 4'd7;
			2'd2: r = 4'd8;
			default: r = 4'd9;
		endcase
		return r;
	endfunction

endpackage

FILE: hdl/gpv_ctrl.sv
module gpv_ctrl
	import gpv_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     enable,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     out_ready,
	output logic     out_valid,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_IDLE, S_LP0, S_LP1, S_LP2, S_BANDS, S_ENV_RD, S_ENV_WR,
		S_RES_MUL, S_RES_ADD, S_FE_MUL, S_FE_VEC, S_NORM, S_ROT,
		S_PHASE, S_DIFF, S_INC_MUL, S_INC_SET, S_ADV,
		S_SYN_STEP, S_SYN_ROM, S_SYN_MUL, S_SYN_ACC,
		S_G1_MUL, S_G1, S_G2_MUL, S_G2, S_G3_MUL, S_G3, S_CLAMP,
		S_FINISH, S_ZERO
	} state_t;

	state_t              state_q;
	logic [BAND_W-1:0]   band_q;
	logic [ITER_W-1:0]   iter_q;
	logic                out_valid_q;
	logic                slot_free;
	logic                last_band;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;
	assign last_band = (band_q == BAND_W'(BAND_COUNT - 1));

	// decode the datapath command from the state
	always_comb begin
		cmd.band = band_q;
		cmd.iter = iter_q;
		case (state_q)
			S_IDLE:     cmd.op = in_valid ? OP_LOAD : OP_NONE;
			S_LP0:      cmd.op = OP_LP0;
			S_LP1:      cmd.op = OP_LP1;
			S_LP2:      cmd.op = OP_LP2;
			S_BANDS:    cmd.op = OP_BANDS;
			S_ENV_RD:   cmd.op = OP_ENV_RD;
			S_ENV_WR:   cmd.op = OP_ENV_WR;
			S_RES_MUL:  cmd.op = OP_RES_MUL;
			S_RES_ADD:  cmd.op = OP_RES_ADD;
			S_FE_MUL:   cmd.op = OP_FE_MUL;
			S_FE_VEC:   cmd.op = OP_FE_VEC;
			S_NORM:     cmd.op = (!stat.vec_zero && stat.norm_small) ? OP_NORM : OP_NONE;
			S_ROT:      cmd.op = OP_ROT;
			S_PHASE:    cmd.op = OP_PHASE;
			S_DIFF:     cmd.op = OP_DIFF;
			S_INC_MUL:  cmd.op = OP_INC_MUL;
			S_INC_SET:  cmd.op = OP_INC_SET;
			S_ADV:      cmd.op = OP_ADV;
			S_SYN_STEP: cmd.op = OP_SYN_STEP;
			S_SYN_ROM:  cmd.op = OP_SYN_ROM;
			S_SYN_MUL:  cmd.op = OP_SYN_MUL;
			S_SYN_ACC:  cmd.op = OP_SYN_ACC;
			S_G1_MUL:   cmd.op = OP_G1_MUL;
			S_G1:       cmd.op = OP_G1;
			S_G2_MUL:   cmd.op = OP_G2_MUL;
			S_G2:       cmd.op = OP_G2;
			S_G3_MUL:   cmd.op = OP_G3_MUL;
			S_G3:       cmd.op = OP_G3;
			S_CLAMP:    cmd.op = OP_CLAMP;
			S_FINISH:   cmd.op = slot_free ? OP_OUT : OP_NONE;
			S_ZERO:     cmd.op = slot_free ? OP_OUT_ZERO : OP_NONE;
			default:    cmd.op = OP_NONE;
		endcase
	end

	// sequence one request through the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			band_q      <= '0;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// raise valid on a finished result, drop it once taken
			if ((state_q inside {S_FINISH, S_ZERO}) && slot_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					band_q <= '0;
					if (in_valid)
						state_q <= enable ? S_LP0 : S_ZERO;
				end
				S_LP0:    state_q <= S_LP1;
				S_LP1:    state_q <= S_LP2;
				S_LP2:    state_q <= S_BANDS;
				S_BANDS:  state_q <= S_ENV_RD;
				S_ENV_RD: state_q <= S_ENV_WR;
				S_ENV_WR: begin
					band_q  <= band_q + 1'b1;
					state_q <= last_band ? S_RES_MUL : S_ENV_RD;
				end
				S_RES_MUL: state_q <= S_RES_ADD;
				S_RES_ADD: begin
					band_q <= band_q + 1'b1;
					if (!last_band)
						state_q <= S_RES_MUL;
					else
						state_q <= stat.frame_last ? S_FE_MUL : S_ADV;
				end
				S_FE_MUL: state_q <= S_FE_VEC;
				S_FE_VEC: state_q <= S_NORM;
				S_NORM: begin
					iter_q <= '0;
					if (stat.vec_zero)
						state_q <= S_PHASE;
					else if (!stat.norm_small)
						state_q <= S_ROT;
				end
				S_ROT: begin
					iter_q <= iter_q + 1'b1;
					if (iter_q == ITER_W'(CORDIC_STEPS - 1))
						state_q <= S_PHASE;
				end
				S_PHASE:   state_q <= S_DIFF;
				S_DIFF:    state_q <= S_INC_MUL;
				S_INC_MUL: state_q <= S_INC_SET;
				S_INC_SET: begin
					band_q  <= band_q + 1'b1;
					state_q <= last_band ? S_ADV : S_FE_MUL;
				end
				S_ADV:      state_q <= S_SYN_STEP;
				S_SYN_STEP: state_q <= S_SYN_ROM;
				S_SYN_ROM:  state_q <= S_SYN_MUL;
				S_SYN_MUL:  state_q <= S_SYN_ACC;
				S_SYN_ACC: begin
					band_q  <= band_q + 1'b1;
					state_q <= last_band ? S_G1_MUL : S_SYN_STEP;
				end
				S_G1_MUL: state_q <= S_G1;
				S_G1:     state_q <= S_G2_MUL;
				S_G2_MUL: state_q <= S_G2;
				S_G2:     state_q <= S_G3_MUL;
				S_G3_MUL: state_q <= S_G3;
				S_G3:     state_q <= S_CLAMP;
				S_CLAMP:  state_q <= S_FINISH;
				S_FINISH, S_ZERO: begin
					if (slot_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: hdl/gpv_dp.sv
module gpv_dp
	import gpv_pkg::*;
#(
	parameter int FRAME_LEN = FRAME_LEN_DEF,
	parameter int SINE_ENTRIES = SINE_ENTRIES_DEF,
	parameter int AVG_WINDOW = AVG_WINDOW_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dp_cmd_t                    cmd,
	output dp_stat_t                   stat,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic [GAIN_W-1:0]          intensity_gain,
	input  logic [GAIN_W-1:0]          harmonic_gain,
	input  logic [GAIN_W-1:0]          modulation_gain,
	input  coef_t                      coef [BAND_COUNT],
	output logic signed [OUT_W-1:0]    audio_out
);

	localparam int LP_W = 17;
	localparam int BV_W = 17;
	localparam int HP_W = $clog2(AVG_WINDOW);
	localparam int HIST_DEPTH = BAND_COUNT * AVG_WINDOW;
	localparam int HA_W = $clog2(HIST_DEPTH);
	localparam int ENV_SUM_W = BV_W + $clog2(AVG_WINDOW);
	localparam int FP_W = $clog2(FRAME_LEN);
	localparam int RES_W = 32;
	localparam int CW = 37;
	localparam int AW = $clog2(SINE_ENTRIES);
	localparam int SW = $clog2(SINE_ENTRIES + 1);
	localparam int V_W = 32;
	localparam int GM_W = 42;

	// level = sum / AVG_WINDOW by reciprocal multiplication
	localparam int S_ENV = ENV_SUM_W + $clog2(AVG_WINDOW);
	localparam int ME_W = ENV_SUM_W + 2;
	localparam longint unsigned M_ENV = ((64'd1 << S_ENV) + AVG_WINDOW - 1) / AVG_WINDOW;
	// phase step = |diff| / FRAME_LEN by reciprocal multiplication
	localparam int S_F = PHASE_W + $clog2(FRAME_LEN);
	localparam int MF_W = PHASE_W + 2;
	localparam longint unsigned M_F = ((64'd1 << S_F) + FRAME_LEN - 1) / FRAME_LEN;

	localparam logic signed [CW-1:0] NORM_LIM = CW'(64'sd1 <<< 30);
	localparam longint TWO_PI = 64'sd6746518852;
	localparam longint PI_Q30 = 64'sd3373259426;
	localparam longint HALF_PI = 64'sd1686629713;

	typedef logic signed [7:0] sine_tab_t [SINE_ENTRIES];

	// sine table: 127*sin over one turn from a Q30 Taylor series
	function automatic sine_tab_t gen_sine();
		sine_tab_t t;
		longint a;
		longint x2;
		longint term;
		longint sum;
		logic neg;
		for (int k = 0; k < SINE_ENTRIES; k++) begin
			a = (TWO_PI * longint'(k)) / SINE_ENTRIES;
			neg = 1'b0;
			if (a >= PI_Q30) begin
				a = a - PI_Q30;
				neg = 1'b1;
			end
			if (a > HALF_PI)
				a = PI_Q30 - a;
			x2 = (a * a) >>> 30;
			term = a;
			sum = a;
			term = ((term * x2) >>> 30) / 6;
			sum = sum - term;
			term = ((term * x2) >>> 30) / 20;
			sum = sum + term;
			term = ((term * x2) >>> 30) / 42;
			sum = sum - term;
			term = ((term * x2) >>> 30) / 72;
			sum = sum + term;
			term = ((term * x2) >>> 30) / 110;
			sum = sum - term;
			if (sum < 0)
				sum = 0;
			sum = (127 * sum + (64'sd1 <<< 29)) >>> 30;
			t[k] = neg ? -8'(sum) : 8'(sum);
		end
		return t;
	endfunction

	localparam sine_tab_t SINE_TAB = gen_sine();

	// model state
	logic signed [LP_W-1:0]      lp_q [3];
	logic [ENV_SUM_W-1:0]        sum_q [BAND_COUNT];
	logic signed [RES_W-1:0]     r1_q [BAND_COUNT];
	logic signed [RES_W-1:0]     r2_q [BAND_COUNT];
	logic [PHASE_W-1:0]          unwr_q [BAND_COUNT];
	logic [PHASE_W-1:0]          synth_q [BAND_COUNT];
	logic [PHASE_W-1:0]          inc_q [BAND_COUNT];
	logic [HP_W-1:0]             hist_pos_q;
	logic [FP_W-1:0]             frame_pos_q;
	logic [HIST_DEPTH-1:0]       hist_vld_q;

	// history memory
	logic [BV_W-1:0]             hist_mem [HIST_DEPTH];
	logic [BV_W-1:0]             hist_rd_q;
	logic                        hist_rv_q;

	// working registers
	logic signed [SAMPLE_W-1:0]  x_q;
	logic [BV_W-1:0]             bv_q [BAND_COUNT];
	logic signed [48:0]          prod_s1;
	logic signed [47:0]          pc_s1;
	logic signed [47:0]          ps_s1;
	logic signed [CW-1:0]        cx_q;
	logic signed [CW-1:0]        cy_q;
	logic [PHASE_W-1:0]          cz_q;
	logic                        vz_q;
	logic                        dneg_q;
	logic [PHASE_W-1:0]          dmag_q;
	logic [PHASE_W+MF_W-1:0]     qf_s1;
	logic [PHASE_W+SW-1:0]       ix_s1;
	logic [ENV_SUM_W+ME_W-1:0]   lv_s1;
	logic signed [7:0]           rom_q;
	logic [BV_W-1:0]             lvl_q;
	logic signed [25:0]          sp_q;
	logic signed [V_W-1:0]       acc_q;
	logic signed [GM_W-1:0]      gm_s1;
	logic signed [OUT_W-1:0]     audio_q;

	// combinational helpers
	logic [BAND_W-1:0]           b;
	logic [HA_W-1:0]             hist_addr;
	logic signed [LP_W:0]        d0, d1, d2, d3;
	logic [LP_W:0]               a0, a1, a2, a3;
	logic [BV_W-1:0]             old_val;
	logic [ENV_SUM_W:0]          sum_new;
	logic signed [35:0]          s0;
	logic signed [CW-1:0]        re, im;
	logic signed [CW-1:0]        sx, sy;
	logic [PHASE_W-1:0]          diff;
	logic [PHASE_W-1:0]          quo;
	logic [PHASE_W-1:0]          sp_new;
	logic signed [GM_W-1:0]      g3_sum;
	logic signed [7:0]           clamp_v;

	assign b = cmd.band;
	assign hist_addr = HA_W'(b) * HA_W'(AVG_WINDOW) + HA_W'(hist_pos_q);

	// band signals from the lowpass cascade
	always_comb begin
		d0 = (LP_W+1)'(lp_q[2]);
		d1 = (LP_W+1)'(lp_q[1]) - (LP_W+1)'(lp_q[2]);
		d2 = (LP_W+1)'(lp_q[0]) - (LP_W+1)'(lp_q[1]);
		d3 = (LP_W+1)'(x_q) - (LP_W+1)'(lp_q[0]);
		a0 = d0[LP_W] ? (LP_W+1)'(-d0) : (LP_W+1)'(d0);
		a1 = d1[LP_W] ? (LP_W+1)'(-d1) : (LP_W+1)'(d1);
		a2 = d2[LP_W] ? (LP_W+1)'(-d2) : (LP_W+1)'(d2);
		a3 = d3[LP_W] ? (LP_W+1)'(-d3) : (LP_W+1)'(d3);
	end

	always_comb begin
		old_val = hist_rv_q ? hist_rd_q : '0;
		sum_new = (ENV_SUM_W+1)'(sum_q[b]) + (ENV_SUM_W+1)'(bv_q[b]) - (ENV_SUM_W+1)'(old_val);
		s0 = 36'(x_q) + 36'(prod_s1 >>> 15) - 36'(r2_q[b]);
		re = CW'(r1_q[b]) - CW'(pc_s1 >>> 15);
		im = CW'(ps_s1 >>> 15);
		sx = cx_q >>> cmd.iter;
		sy = cy_q >>> cmd.iter;
		diff = unwr_q[b] - synth_q[b];
		quo = PHASE_W'(qf_s1 >> S_F);
		sp_new = synth_q[b] + inc_q[b];
		g3_sum = GM_W'(acc_q) + (gm_s1 >>> 8);
		if (acc_q > 32'sd127)
			clamp_v = 8'sd127;
		else if (acc_q < -32'sd127)
			clamp_v = -8'sd127;
		else
			clamp_v = 8'(acc_q);
	end

	assign stat.frame_last = (frame_pos_q == FP_W'(FRAME_LEN - 1));
	assign stat.vec_zero   = vz_q;
	assign stat.norm_small = (cx_q < NORM_LIM) && (cy_q < NORM_LIM) && (cy_q > -NORM_LIM);
	assign audio_out       = audio_q;

	// history memory port
	always_ff @(posedge clk) begin
		if (cmd.op == OP_ENV_RD)
			hist_rd_q <= hist_mem[hist_addr];
		if (cmd.op == OP_ENV_WR)
			hist_mem[hist_addr] <= bv_q[b];
	end

	// sine table read
	always_ff @(posedge clk) begin
		if (cmd.op == OP_SYN_ROM)
			rom_q <= SINE_TAB[ix_s1[PHASE_W +: AW]];
	end

	// state that the block keeps between samples
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++)
				lp_q[i] <= '0;
			for (int i = 0; i < BAND_COUNT; i++) begin
				sum_q[i]   <= '0;
				r1_q[i]    <= '0;
				r2_q[i]    <= '0;
				unwr_q[i]  <= '0;
				synth_q[i] <= '0;
				inc_q[i]   <= '0;
			end
			hist_pos_q  <= '0;
			frame_pos_q <= '0;
			hist_vld_q  <= '0;
			hist_rv_q   <= 1'b0;
		end else begin
			case (cmd.op)
				OP_LP0: lp_q[0] <= lp_q[0] + LP_W'(((LP_W+1)'(x_q) - (LP_W+1)'(lp_q[0])) >>> 3);
				OP_LP1: lp_q[1] <= lp_q[1] + LP_W'(((LP_W+1)'(lp_q[0]) - (LP_W+1)'(lp_q[1])) >>> 4);
				OP_LP2: lp_q[2] <= lp_q[2] + LP_W'(((LP_W+1)'(lp_q[1]) - (LP_W+1)'(lp_q[2])) >>> 5);
				OP_ENV_RD: hist_rv_q <= hist_vld_q[hist_addr];
				OP_ENV_WR: begin
					sum_q[b] <= ENV_SUM_W'(sum_new);
					hist_vld_q[hist_addr] <= 1'b1;
				end
				OP_RES_ADD: begin
					r2_q[b] <= r1_q[b];
					r1_q[b] <= s0[RES_W-1:0];
				end
				OP_FE_VEC: begin
					r1_q[b] <= '0;
					r2_q[b] <= '0;
				end
				OP_PHASE: unwr_q[b] <= vz_q ? '0 : cz_q;
				OP_INC_SET: inc_q[b] <= dneg_q ? PHASE_W'(-quo) : quo;
				OP_ADV: begin
					hist_pos_q  <= (hist_pos_q == HP_W'(AVG_WINDOW - 1)) ? '0 : hist_pos_q + 1'b1;
					frame_pos_q <= stat.frame_last ? '0 : frame_pos_q + 1'b1;
				end
				OP_SYN_STEP: synth_q[b] <= sp_new;
				default: ;
			endcase
		end
	end

	// arithmetic working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: x_q <= sample;
			OP_LP0: acc_q <= '0;
			OP_BANDS: begin
				bv_q[0] <= BV_W'(a0 >> 2);
				bv_q[1] <= BV_W'(a1 >> 1);
				bv_q[2] <= BV_W'(a2);
				bv_q[3] <= BV_W'(a3 >> 1);
			end
			OP_RES_MUL: prod_s1 <= 49'($signed(coef[b][16:0])) * 49'(r1_q[b]);
			OP_FE_MUL: begin
				pc_s1 <= 48'($signed(coef[b][32:17])) * 48'(r2_q[b]);
				ps_s1 <= 48'($signed(coef[b][48:33])) * 48'(r2_q[b]);
			end
			OP_FE_VEC: begin
				vz_q <= (re == '0) && (im == '0);
				if (re < 0) begin
					cx_q <= -re;
					cy_q <= -im;
					cz_q <= 16'h8000;
				end else begin
					cx_q <= re;
					cy_q <= im;
					cz_q <= '0;
				end
			end
			OP_NORM: begin
				cx_q <= cx_q <<< 1;
				cy_q <= cy_q <<< 1;
			end
			OP_ROT: begin
				if (cy_q > 0) begin
					cx_q <= cx_q + sy;
					cy_q <= cy_q - sx;
					cz_q <= cz_q + atan_step(cmd.iter);
				end else begin
					cx_q <= cx_q - sy;
					cy_q <= cy_q + sx;
					cz_q <= cz_q - atan_step(cmd.iter);
				end
			end
			OP_DIFF: begin
				dneg_q <= diff[PHASE_W-1];
				dmag_q <= diff[PHASE_W-1] ? PHASE_W'(-diff) : diff;
			end
			OP_INC_MUL: qf_s1 <= (PHASE_W+MF_W)'(dmag_q) * (PHASE_W+MF_W)'(M_F);
			OP_SYN_STEP: begin
				ix_s1 <= (PHASE_W+SW)'(sp_new ^ 16'h8000) * (PHASE_W+SW)'(SINE_ENTRIES);
				lv_s1 <= (ENV_SUM_W+ME_W)'(sum_q[b]) * (ENV_SUM_W+ME_W)'(M_ENV);
			end
			OP_SYN_ROM: lvl_q <= BV_W'(lv_s1 >> S_ENV);
			OP_SYN_MUL: sp_q <= 26'(rom_q) * 26'($signed({1'b0, lvl_q}));
			OP_SYN_ACC: acc_q <= acc_q + V_W'(sp_q >>> band_shift(b));
			OP_G1_MUL: gm_s1 <= GM_W'(acc_q) * GM_W'($signed({1'b0, intensity_gain}));
			OP_G1: acc_q <= V_W'(gm_s1 >>> 8);
			OP_G2_MUL: gm_s1 <= GM_W'(acc_q) * GM_W'($signed({1'b0, harmonic_gain}));
			OP_G2: acc_q <= acc_q + V_W'(gm_s1 >>> 9);
			OP_G3_MUL: gm_s1 <= GM_W'(acc_q) * GM_W'($signed({1'b0, modulation_gain}));
			OP_G3: acc_q <= V_W'(g3_sum >>> 1);
			OP_CLAMP: gm_s1 <= GM_W'(clamp_v) * 42'sd255;
			OP_OUT: audio_q <= OUT_W'(gm_s1 >>> 7);
			OP_OUT_ZERO: audio_q <= '0;
			default: ;
		endcase
	end

endmodule

FILE: hdl/goertzel_phase_vocoder.sv
// Channel vocoder with Goertzel phase tracking: one 9-bit output sample for
// each 16-bit input sample, in order. A controller steps a shared datapath
// through the lowpass cascade, band levels, resonators and synthesis; a new
// sample is taken only after the last result has gone to the output register.
// At the last sample of each frame the four band phases are found by a shared
// CORDIC unit: products and vector set-up, up to 30 normalizing shifts and 15
// rotations (none for a zero vector), then phase, difference and phase step
// for each band. A finished result waits in the output register while the
// next sample is taken in; the result after it waits in the datapath until
// that register is free. With enable low each sample yields 0 without the
// datapath steps, and no state changes.
// The sine table is a registered ROM; the envelope history memory needs no
// clearing pass.
module goertzel_phase_vocoder
	import gpv_pkg::*;
#(
	parameter int FRAME_LEN = FRAME_LEN_DEF,
	parameter int SINE_ENTRIES = SINE_ENTRIES_DEF,
	parameter int AVG_WINDOW = AVG_WINDOW_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [OUT_W-1:0]    audio_out,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [COEF_W-1:0]          cfg_data
);

	logic              enable_q;
	logic [GAIN_W-1:0] intensity_q;
	logic [GAIN_W-1:0] harmonic_q;
	logic [GAIN_W-1:0] modulation_q;
	coef_t             coef_q [BAND_COUNT];
	dp_cmd_t           cmd;
	dp_stat_t          stat;

	assign cfg_ready = 1'b1;

	// take configuration requests
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q     <= 1'b0;
			intensity_q  <= 8'd180;
			harmonic_q   <= 8'd128;
			modulation_q <= 8'd100;
			for (int i = 0; i < BAND_COUNT; i++)
				coef_q[i] <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ENABLE:     enable_q     <= cfg_data[0];
				CFG_INTENSITY:  intensity_q  <= cfg_data[GAIN_W-1:0];
				CFG_HARMONIC:   harmonic_q   <= cfg_data[GAIN_W-1:0];
				CFG_MODULATION: modulation_q <= cfg_data[GAIN_W-1:0];
				CFG_BAND0, CFG_BAND1, CFG_BAND2, CFG_BAND3:
					coef_q[cfg_index[BAND_W-1:0]] <= cfg_data;
				default: ;
			endcase
		end
	end

	gpv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.enable    (enable_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.stat      (stat),
		.cmd       (cmd)
	);

	gpv_dp #(
		.FRAME_LEN    (FRAME_LEN),
		.SINE_ENTRIES (SINE_ENTRIES),
		.AVG_WINDOW   (AVG_WINDOW)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.sample          (sample),
		.intensity_gain  (intensity_q),
		.harmonic_gain   (harmonic_q),
		.modulation_gain (modulation_q),
		.coef            (coef_q),
		.audio_out       (audio_out)
	);

endmodule

FILE: tb/tb_goertzel_phase_vocoder.sv
`timescale 1ns / 100ps

module tb_goertzel_phase_vocoder;
	import gpv_pkg::*;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic signed [OUT_W-1:0]    audio_out;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index = CFG_ENABLE;
	logic [COEF_W-1:0]          cfg_data = '0;

	goertzel_phase_vocoder dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .sample(sample),
		.out_valid(out_valid), .out_ready(out_ready), .audio_out(audio_out),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state
	longint sine_tab[2048];
	longint en_reg, int_gain, harm_gain, mod_gain;
	coef_t  coef_reg[4];
	longint lp_state[3];
	longint env_hist[16];
	int     env_pos;
	longint env_sum[4];
	longint res_a[4], res_b[4];
	longint unwrapped[4], synth_ph[4], ph_step[4];
	int     frame_pos;

	logic signed [OUT_W-1:0] expected_audio[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_req = 0;
	int hold_left = 0;

	// tone generator for random stimulus
	longint tone_acc, tone_step, tone_amp;
	int gen_mode;

	typedef struct {
		logic signed [SAMPLE_W-1:0] s;
		bit                         known;
		logic signed [OUT_W-1:0]    res;
	} stim_row_t;

	// first four rows run disabled: silence is known
	stim_row_t dir_rows[22] = '{
		'{-16'sd32768, 1'b1, 9'sd0}, '{16'sd32767, 1'b1, 9'sd0},
		'{16'sd0, 1'b1, 9'sd0}, '{-16'sd1, 1'b1, 9'sd0},
		'{16'sd32767, 1'b0, 9'sd0}, '{16'sd32767, 1'b0, 9'sd0},
		'{16'sd32767, 1'b0, 9'sd0}, '{-16'sd32768, 1'b0, 9'sd0},
		'{-16'sd32768, 1'b0, 9'sd0}, '{-16'sd32768, 1'b0, 9'sd0},
		'{16'sd0, 1'b0, 9'sd0}, '{16'sd1, 1'b0, 9'sd0},
		'{-16'sd1, 1'b0, 9'sd0}, '{16'sd21845, 1'b0, 9'sd0},
		'{-16'sd21846, 1'b0, 9'sd0}, '{16'sd16384, 1'b0, 9'sd0},
		'{-16'sd16384, 1'b0, 9'sd0}, '{16'sd32767, 1'b0, 9'sd0},
		'{-16'sd32768, 1'b0, 9'sd0}, '{16'sd32767, 1'b0, 9'sd0},
		'{-16'sd32768, 1'b0, 9'sd0}, '{16'sd255, 1'b0, 9'sd0}
	};

	function automatic longint wrap_bits(input longint v, input int w);
		longint u;
		u = v & ((64'sd1 <<< w) - 1);
		if (u[w-1])
			u = u - (64'sd1 <<< w);
		return u;
	endfunction

	function automatic longint magnitude(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic longint sine_value(input int k);
		longint two_pi, pi_q, half_pi, a, x2, term, acc;
		bit neg;
		two_pi = 64'sd6746518852;
		pi_q = 64'sd3373259426;
		half_pi = 64'sd1686629713;
		a = (two_pi * k) / 2048;
		neg = 0;
		if (a >= pi_q) begin
			a -= pi_q;
			neg = 1;
		end
		if (a > half_pi)
			a = pi_q - a;
		x2 = (a * a) >>> 30;
		term = a;
		acc = a;
		for (int n = 1; n <= 5; n++) begin
			term = ((term * x2) >>> 30) / ((2 * n) * (2 * n + 1));
			acc += (n & 1) ? -term : term;
		end
		if (acc < 0)
			acc = 0;
		acc = (127 * acc + (64'sd1 <<< 29)) >>> 30;
		return neg ? -acc : acc;
	endfunction

	// vectoring CORDIC, binary angle result
	function automatic longint cordic_angle(input longint re, input longint im);
		longint x, y, z, m, nx, ny, base;
		x = re;
		y = im;
		z = 0;
		base = 0;
		if (x < 0) begin
			x = -x;
			y = -y;
			base = 32768;
		end
		m = (x > magnitude(y)) ? x : magnitude(y);
		if (m == 0)
			return 0;
		while (m < (64'sd1 <<< 30)) begin
			x *= 2;
			y *= 2;
			m *= 2;
		end
		for (int i = 0; i < 15; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z += longint'(atan_step(4'(i)));
			end else begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z -= longint'(atan_step(4'(i)));
			end
			x = nx;
			y = ny;
		end
		return wrap_bits(base + z, 16);
	endfunction

	task automatic reset_vocoder_state();
		en_reg = 0;
		int_gain = 180;
		harm_gain = 128;
		mod_gain = 100;
		frame_pos = 0;
		env_pos = 0;
		for (int b = 0; b < 4; b++) begin
			coef_reg[b] = '0;
			env_sum[b] = 0;
			res_a[b] = 0;
			res_b[b] = 0;
			unwrapped[b] = 0;
			synth_ph[b] = 0;
			ph_step[b] = 0;
		end
		for (int i = 0; i < 3; i++)
			lp_state[i] = 0;
		for (int i = 0; i < 16; i++)
			env_hist[i] = 0;
	endtask

	// compute the output sample for one accepted request and advance state
	function automatic logic signed [OUT_W-1:0] vocode_sample(
			input logic signed [SAMPLE_W-1:0] s);
		longint x, lp1, lp2, lp3, v, level, prod, c2, s0, cs, sn, re, im, np, delta, diff;
		longint bandval[4];
		longint idx;
		int lvl_sh[4];
		int out_sh[4];
		lvl_sh = '{8, 7, 7, 8};
		out_sh = '{1, 0, 1, 1};
		if (en_reg == 0)
			return '0;
		x = longint'(s);
		lp_state[0] += (x - lp_state[0]) >>> 3;
		lp_state[1] += (lp_state[0] - lp_state[1]) >>> 4;
		lp_state[2] += (lp_state[1] - lp_state[2]) >>> 5;
		lp1 = lp_state[0];
		lp2 = lp_state[1];
		lp3 = lp_state[2];
		bandval[0] = magnitude(lp3) >>> 2;
		bandval[1] = magnitude(lp2 - lp3) >>> 1;
		bandval[2] = magnitude(lp1 - lp2);
		bandval[3] = magnitude(x - lp1) >>> 1;
		for (int b = 0; b < 4; b++) begin
			env_sum[b] += bandval[b] - env_hist[b * 4 + env_pos];
			env_hist[b * 4 + env_pos] = bandval[b];
		end
		env_pos = (env_pos + 1) % 4;

		// resonators
		for (int b = 0; b < 4; b++) begin
			c2 = wrap_bits(longint'(coef_reg[b][16:0]), 17);
			s0 = x + ((c2 * res_a[b]) >>> 15) - res_b[b];
			res_b[b] = res_a[b];
			res_a[b] = wrap_bits(s0, 32);
		end

		// frame end: new phases and phase steps
		frame_pos++;
		if (frame_pos >= 32) begin
			for (int b = 0; b < 4; b++) begin
				cs = wrap_bits(longint'(coef_reg[b][32:17]), 16);
				sn = wrap_bits(longint'(coef_reg[b][48:33]), 16);
				re = res_a[b] - ((cs * res_b[b]) >>> 15);
				im = (sn * res_b[b]) >>> 15;
				np = cordic_angle(re, im);
				delta = wrap_bits(np - unwrapped[b], 16);
				unwrapped[b] = wrap_bits(unwrapped[b] + delta, 16);
				diff = wrap_bits(unwrapped[b] - synth_ph[b], 16);
				ph_step[b] = diff / 32;
				res_a[b] = 0;
				res_b[b] = 0;
			end
			frame_pos = 0;
		end

		// synthesis and gains
		v = 0;
		for (int b = 0; b < 4; b++) begin
			synth_ph[b] = wrap_bits(synth_ph[b] + ph_step[b], 16);
			idx = (((synth_ph[b] + 32768) * 2048) >>> 16) % 2048;
			level = env_sum[b] / 4;
			prod = (sine_tab[idx] * level) >>> lvl_sh[b];
			v += prod >>> out_sh[b];
		end
		v = (v * int_gain) >>> 8;
		v += (v * harm_gain) >>> 9;
		v = (v + ((v * mod_gain) >>> 8)) >>> 1;
		if (v > 127)
			v = 127;
		if (v < -127)
			v = -127;
		v = (v * 255) >>> 7;
		return v[OUT_W-1:0];
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= 40)
			$display("%0t: %s", $realtime, msg);
	endtask

	// offer one request, wait for acceptance, queue its expected output
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input bit known,
			input logic signed [OUT_W-1:0] known_res);
		logic signed [OUT_W-1:0] r;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		do
			@(posedge clk);
		while (!in_ready);
		r = vocode_sample(s);
		expected_audio.push_back(known ? known_res : r);
	endtask

	// valid stays high between back-to-back writes; the caller drops it
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input coef_t value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_ENABLE: en_reg = value[0];
			CFG_INTENSITY: int_gain = value[7:0];
			CFG_HARMONIC: harm_gain = value[7:0];
			CFG_MODULATION: mod_gain = value[7:0];
			CFG_BAND0: coef_reg[0] = value;
			CFG_BAND1: coef_reg[1] = value;
			CFG_BAND2: coef_reg[2] = value;
			default: coef_reg[3] = value;
		endcase
	endtask

	// drop valid, wait for every output, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_audio.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	function automatic coef_t pack_coef(input int c2, input int cs, input int sn);
		logic [16:0] c2b;
		logic [15:0] csb, snb;
		c2b = c2[16:0];
		csb = cs[15:0];
		snb = sn[15:0];
		return {snb, csb, c2b};
	endfunction

	task automatic write_all(input bit en, input int gi, input int gh, input int gm,
			input int coef_set);
		coef_t c[4];
		case (coef_set)
			0: begin
				c[0] = pack_coef(64277, 32138, 6393);
				c[1] = pack_coef(60547, 30274, 12540);
				c[2] = pack_coef(46341, 23170, 23170);
				c[3] = pack_coef(0, 0, 32767);
			end
			1: begin
				c[0] = pack_coef(54491, 27246, 18205);
				c[1] = pack_coef(36410, 18205, 27246);
				c[2] = pack_coef(25080, 12540, 30274);
				c[3] = pack_coef(-46341, -23170, 23170);
			end
			default: begin
				for (int b = 0; b < 4; b++)
					c[b] = coef_t'({$urandom, $urandom});
			end
		endcase
		write_reg(CFG_INTENSITY, coef_t'(gi));
		write_reg(CFG_HARMONIC, coef_t'(gh));
		write_reg(CFG_MODULATION, coef_t'(gm));
		write_reg(CFG_BAND0, c[0]);
		write_reg(CFG_BAND1, c[1]);
		write_reg(CFG_BAND2, c[2]);
		write_reg(CFG_BAND3, c[3]);
		write_reg(CFG_ENABLE, coef_t'(en));
		cfg_valid <= 1'b0;
	endtask

	// pick a waveform per block of samples: tones dominate so phases track
	function automatic logic signed [SAMPLE_W-1:0] next_sample(input int n);
		longint t;
		if (n % 32 == 0) begin
			gen_mode = $urandom_range(0, 9);
			tone_step = $urandom_range(1, 400);
			tone_amp = $urandom_range(1, 258);
		end
		tone_acc = (tone_acc + tone_step) % 2048;
		case (gen_mode)
			0, 1, 2, 3: t = sine_tab[tone_acc] * tone_amp;
			4: t = $signed(16'($urandom));
			5: t = $signed(longint'($urandom_range(0, 510))) - 255;
			6: t = 0;
			7: t = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
			default: t = sine_tab[tone_acc] * (tone_amp / 2) +
					$signed(longint'($urandom_range(0, 2000))) - 1000;
		endcase
		if (t > 32767)
			t = 32767;
		if (t < -32768)
			t = -32768;
		return t[15:0];
	endfunction

	// receiver: random stalls, or a long hold-off when requested
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = 700;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// compare each accepted output with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_audio.size() == 0) begin
				report_mismatch($sformatf("unexpected output %0d", audio_out));
			end else begin
				logic signed [OUT_W-1:0] e;
				e = expected_audio.pop_front();
				if (audio_out !== e)
					report_mismatch($sformatf("audio_out %0d, expected %0d", audio_out, e));
			end
		end
	end

	initial begin
		#40ms;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int n;
		for (int k = 0; k < 2048; k++)
			sine_tab[k] = sine_value(k);
		reset_vocoder_state();
		tone_acc = 0;
		gen_mode = 0;
		tone_step = 1;
		tone_amp = 1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows: disabled first, then enabled with fixed values and coefficients
		for (int i = 0; i < 22; i++) begin
			if (i == 4) begin
				drain();
				write_all(1'b1, 180, 128, 100, 0);
			end
			send_sample(dir_rows[i].s, dir_rows[i].known, dir_rows[i].res);
		end

		n = 0;
		for (int p = 0; p < 7; p++) begin
			drain();
			case (p)
				0: begin
					send_idle_pct = 0; recv_stall_pct = 0;
					write_all(1'b1, 180, 128, 100, 0);
				end
				1: begin
					send_idle_pct = 79; recv_stall_pct = 0;
					write_all(1'b1, 255, 200, 200, 1);
				end
				2: begin
					send_idle_pct = 0; recv_stall_pct = 79;
					write_all(1'b1, 120, 80, 50, 2);
				end
				3: begin
					send_idle_pct = 34; recv_stall_pct = 34;
					write_all(1'b0, 200, 150, 120, 0);
				end
				4: begin
					send_idle_pct = 0; recv_stall_pct = 0;
					write_all(1'b1, $urandom_range(120, 255), $urandom_range(80, 200),
						$urandom_range(50, 200), 0);
					hold_req = 1;
				end
				5: begin
					send_idle_pct = 34; recv_stall_pct = 34;
					write_all(1'b1, $urandom_range(120, 255), $urandom_range(80, 200),
						$urandom_range(50, 200), 2);
				end
				default: begin
					send_idle_pct = 79; recv_stall_pct = 79;
					write_all(1'b1, 255, 80, 200, 1);
				end
			endcase
			for (int i = 0; i < 190; i++) begin
				send_sample(next_sample(n), 1'b0, '0);
				n++;
			end
		end

		drain();
		if (expected_audio.size() != 0)
			report_mismatch("outputs missing at end of run");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
